### rtl/core/lsms_pkg.sv
// Shared types, codes and helpers for the limit switch motion sequencer.
`timescale 1ns / 1ps

package lsms_pkg;

    localparam int TimerBits = 16;
    localparam int CmpW      = (TimerBits > 16) ? TimerBits : 16;

    localparam logic MODE_RAISE = 1'b0;
    localparam logic MODE_LOWER = 1'b1;

    // Pulse phase codes
    localparam logic [1:0] PH_OFF   = 2'd0;
    localparam logic [1:0] PH_ON    = 2'd1;
    localparam logic [1:0] PH_FIRST = 2'd2;

    // Status codes as seen on the result channel
    localparam logic [2:0] CODE_NOT_STARTED = 3'd0;
    localparam logic [2:0] CODE_WORKING     = 3'd1;
    localparam logic [2:0] CODE_DONE        = 3'd2;
    localparam logic [2:0] CODE_COMPLETE    = 3'd3;
    localparam logic [2:0] CODE_ERROR       = 3'd4;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_RAISE_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_LOWER_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_FIRST_ON      = 3'd2;
    localparam logic [2:0] REG_PULSE_ON      = 3'd3;
    localparam logic [2:0] REG_PULSE_OFF     = 3'd4;

    typedef enum logic [4:0] {
        ST_NOT_STARTED = 5'b00001,
        ST_WORKING     = 5'b00010,
        ST_DONE        = 5'b00100,
        ST_COMPLETE    = 5'b01000,
        ST_ERROR       = 5'b10000
    } status_t;

    function automatic logic [2:0] status_code(input status_t st);
        logic [2:0] code;
        unique case (st)
            ST_NOT_STARTED: code = CODE_NOT_STARTED;
            ST_WORKING:     code = CODE_WORKING;
            ST_DONE:        code = CODE_DONE;
            ST_COMPLETE:    code = CODE_COMPLETE;
            ST_ERROR:       code = CODE_ERROR;
            default:        code = CODE_NOT_STARTED;
        endcase
        return code;
    endfunction

endpackage

### rtl/core/limit_switch_motion_sequencer.sv
// Limit switch motion sequencer: poll stepping, result buffering and registers.
`timescale 1ns / 1ps
//
// Usage
//   Each request on the s_ channel is one poll of the raise sequence
//   (s_tuser = 0) or the lower sequence (s_tuser = 1). The poll adds its
//   tick count to a saturating elapsed timer, optionally restarts, steps
//   the shared status and answers with one result on the m_ channel:
//   status code, motor drive and hold magnet.
//   The result is registered at the accepting edge (in the skid entry while
//   a result waits). Throughput: one poll per cycle while s_tready is high;
//   state updates at the accepting edge, a single pass of compare and add logic.
//   A two-entry result buffer (output register plus skid) lets a poll be
//   taken while one finished result waits; s_tready drops only when both
//   entries are full, i.e. after the receiver stalls two results.
//   Configuration: APB registers raise_timeout, lower_timeout,
//   first_on_ticks, pulse_on_ticks, pulse_off_ticks at 0x0..0x10.
//   Write them only while no poll is in flight.
//   Reset (aresetn low, synchronous) returns the status to not started,
//   clears timer, phase and mark, turns motor and magnet off, empties the
//   result buffer and loads the default register values.
module limit_switch_motion_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // poll requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [0] restart, [1] switch_up, [2] switch_down,
                                   // [10:3] ticks_passed, [15:11] zero
    input  logic [0:0]  s_tuser,   // [0] mode
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [2:0] status, [3] motor_drive, [4] magnet_hold,
                                   // [7:5] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TW = lsms_pkg::TimerBits;
    localparam int CW = lsms_pkg::CmpW;

    // ---------------- configuration registers ----------------
    logic [15:0] raise_timeout_reg;
    logic [15:0] lower_timeout_reg;
    logic [7:0]  first_on_reg;
    logic [7:0]  pulse_on_reg;
    logic [7:0]  pulse_off_reg;
    logic        cfg_write;
    logic [2:0]  cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raise_timeout_reg <= 16'd3000;
            lower_timeout_reg <= 16'd3000;
            first_on_reg      <= 8'd34;
            pulse_on_reg      <= 8'd10;
            pulse_off_reg     <= 8'd5;
        end else if (cfg_write) begin
            unique case (cfg_index)
                lsms_pkg::REG_RAISE_TIMEOUT: raise_timeout_reg <= pwdata[15:0];
                lsms_pkg::REG_LOWER_TIMEOUT: lower_timeout_reg <= pwdata[15:0];
                lsms_pkg::REG_FIRST_ON:      first_on_reg      <= pwdata[7:0];
                lsms_pkg::REG_PULSE_ON:      pulse_on_reg      <= pwdata[7:0];
                lsms_pkg::REG_PULSE_OFF:     pulse_off_reg     <= pwdata[7:0];
                default: ;  // drop writes to unknown addresses
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            lsms_pkg::REG_RAISE_TIMEOUT: prdata = {16'd0, raise_timeout_reg};
            lsms_pkg::REG_LOWER_TIMEOUT: prdata = {16'd0, lower_timeout_reg};
            lsms_pkg::REG_FIRST_ON:      prdata = {24'd0, first_on_reg};
            lsms_pkg::REG_PULSE_ON:      prdata = {24'd0, pulse_on_reg};
            lsms_pkg::REG_PULSE_OFF:     prdata = {24'd0, pulse_off_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // ---------------- poll fields ----------------
    logic       in_mode;
    logic       in_restart;
    logic       in_up;
    logic       in_down;
    logic [7:0] in_ticks;

    assign in_mode    = s_tuser[0];
    assign in_restart = s_tdata[0];
    assign in_up      = s_tdata[1];
    assign in_down    = s_tdata[2];
    assign in_ticks   = s_tdata[10:3];

    // ---------------- sequencer state ----------------
    lsms_pkg::status_t status_reg, status_next, status_start;
    logic [TW-1:0] elapsed_reg, elapsed_next;
    logic [TW-1:0] mark_reg, mark_next;
    logic [1:0]    phase_reg, phase_next;
    logic          motor_reg, motor_next;
    logic          magnet_reg, magnet_next;

    logic [TW:0]   elapsed_sum;
    logic [TW-1:0] elapsed_sat;
    logic [TW-1:0] since_mark;
    logic          raise_expired;
    logic          lower_expired;

    // Add ticks first and hold at all ones instead of wrapping.
    assign elapsed_sum   = {1'b0, elapsed_reg} + (TW + 1)'(in_ticks);
    assign elapsed_sat   = elapsed_sum[TW] ? {TW{1'b1}} : elapsed_sum[TW-1:0];
    assign since_mark    = elapsed_sat - mark_reg;
    assign raise_expired = CW'(elapsed_sat) > CW'(raise_timeout_reg);
    assign lower_expired = CW'(elapsed_sat) > CW'(lower_timeout_reg);
    assign status_start  = in_restart ? lsms_pkg::ST_NOT_STARTED : status_reg;

    always_comb begin
        status_next  = status_start;
        elapsed_next = elapsed_sat;
        mark_next    = mark_reg;
        phase_next   = phase_reg;
        motor_next   = motor_reg;
        magnet_next  = magnet_reg;
        if (in_mode == lsms_pkg::MODE_RAISE) begin
            unique case (status_start)
                lsms_pkg::ST_NOT_STARTED: begin
                    if (in_up) begin
                        status_next = lsms_pkg::ST_DONE;
                    end else begin
                        // Start raising: energize both, run the initial on phase.
                        motor_next   = 1'b1;
                        magnet_next  = 1'b1;
                        elapsed_next = '0;
                        mark_next    = '0;
                        phase_next   = lsms_pkg::PH_FIRST;
                        status_next  = lsms_pkg::ST_WORKING;
                    end
                end
                lsms_pkg::ST_WORKING: begin
                    if (in_up) begin
                        status_next = lsms_pkg::ST_DONE;
                    end else if (raise_expired) begin
                        motor_next  = 1'b0;
                        magnet_next = 1'b0;
                        status_next = lsms_pkg::ST_ERROR;
                    end else begin
                        case (phase_reg)
                            lsms_pkg::PH_FIRST: begin
                                // Motor keeps running into the first off phase.
                                if (since_mark >= TW'(first_on_reg)) begin
                                    mark_next  = elapsed_sat;
                                    phase_next = lsms_pkg::PH_OFF;
                                end
                            end
                            lsms_pkg::PH_ON: begin
                                if (since_mark >= TW'(pulse_on_reg)) begin
                                    mark_next  = elapsed_sat;
                                    phase_next = lsms_pkg::PH_OFF;
                                    motor_next = 1'b0;
                                end
                            end
                            lsms_pkg::PH_OFF: begin
                                if (since_mark >= TW'(pulse_off_reg)) begin
                                    mark_next  = elapsed_sat;
                                    phase_next = lsms_pkg::PH_ON;
                                    motor_next = 1'b1;
                                end
                            end
                            default: ;  // unused phase code: no pulse action
                        endcase
                    end
                end
                lsms_pkg::ST_DONE: begin
                    motor_next  = 1'b0;
                    status_next = lsms_pkg::ST_COMPLETE;
                end
                default: ;  // complete and error hold until restart
            endcase
        end else begin
            unique case (status_start)
                lsms_pkg::ST_NOT_STARTED: begin
                    if (in_down) begin
                        status_next = lsms_pkg::ST_DONE;
                    end else begin
                        magnet_next  = 1'b0;
                        elapsed_next = '0;
                        status_next  = lsms_pkg::ST_WORKING;
                    end
                end
                lsms_pkg::ST_WORKING: begin
                    if (in_down) begin
                        status_next = lsms_pkg::ST_DONE;
                    end else if (lower_expired) begin
                        status_next = lsms_pkg::ST_ERROR;
                    end
                end
                lsms_pkg::ST_DONE: begin
                    status_next = lsms_pkg::ST_COMPLETE;
                end
                default: ;
            endcase
        end
    end

    // ---------------- handshake and result buffer ----------------
    logic       s_accept;
    logic       m_drain;
    logic [7:0] result;
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       skid_valid_reg;
    logic [7:0] skid_data_reg;

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_drain  = out_valid_reg && m_tready;
    assign result   = {3'd0, magnet_next, motor_next, lsms_pkg::status_code(status_next)};
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Advance the state at every accepted poll.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg  <= lsms_pkg::ST_NOT_STARTED;
            elapsed_reg <= '0;
            mark_reg    <= '0;
            phase_reg   <= lsms_pkg::PH_OFF;
            motor_reg   <= 1'b0;
            magnet_reg  <= 1'b0;
        end else if (s_accept) begin
            status_reg  <= status_next;
            elapsed_reg <= elapsed_next;
            mark_reg    <= mark_next;
            phase_reg   <= phase_next;
            motor_reg   <= motor_next;
            magnet_reg  <= magnet_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_drain) begin
            if (skid_valid_reg) begin
                // Skid full means s_tready is low: no new poll this cycle.
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= s_accept;
                if (s_accept) begin
                    out_data_reg <= result;
                end
            end
        end else if (s_accept) begin
            if (!out_valid_reg) begin
                out_data_reg  <= result;
                out_valid_reg <= 1'b1;
            end else begin
                // Hold the result aside while the receiver stalls.
                skid_data_reg  <= result;
                skid_valid_reg <= 1'b1;
            end
        end
    end

`ifndef SYNTH
    // The skid entry is only ever filled behind a waiting output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // Complete and error hold without restart.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !in_restart &&
         (status_reg == lsms_pkg::ST_COMPLETE || status_reg == lsms_pkg::ST_ERROR))
        |=> ($stable(status_reg) && $stable(motor_reg) && $stable(magnet_reg)))
        else $error("terminal status changed without restart");

    // A restarted raise with the upper switch open starts the motor run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_restart && in_mode == lsms_pkg::MODE_RAISE && !in_up)
        |=> (status_reg == lsms_pkg::ST_WORKING && motor_reg && magnet_reg &&
             phase_reg == lsms_pkg::PH_FIRST && elapsed_reg == '0))
        else $error("raise start did not energize motor and magnet");
`endif

endmodule
